// ----- rtl/core/dtme_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtme_pkg
// shared types and constants for the dpcm trellis search block
// ----------------------------------------------------------------------------
package dtme_pkg;

  localparam int LEVELS      = 256;
  localparam int LEVEL_BITS  = 8;
  localparam int START_LEVEL = 128;
  localparam int TOP_LEVEL   = 255;
  localparam int STEP_BITS   = 9;
  localparam int OUT_BITS    = 40;
  localparam int CFG_IDX_BITS = 2;
  localparam int CFG_DATA_BITS = 63;

  localparam logic [CFG_IDX_BITS-1:0] REG_ENTRY_COUNT = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_CODE_GROUP0 = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_CODE_GROUP1 = 2'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_CODE_GROUP2 = 2'd3;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_RELAX,
    ST_COPY,
    ST_MIN,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic init_clear;
    logic start;
    logic relax;
    logic copy;
    logic min_scan;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic relax_done;
    logic sweep_done;
    logic last_flag;
  } dp_sts_t;

endpackage

// ----- rtl/core/dpcm_trellis_min_error_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpcm_trellis_min_error_top
// trellis search of dpcm codebook choices for least squared error
// ----------------------------------------------------------------------------
// channel | dir | handshake            | payload
// in_     | in  | in_tvalid/in_tready  | tdata[7:0] sample, tlast last_sample
// out_    | out | out_tvalid/out_tready| tdata[39:0] total_cost
// cfg_    | in  | cfg_valid/cfg_ready  | cfg_index[1:0], cfg_data[62:0]
// one item is accepted, relaxed over every level and each of min(entry_count,16)
// steps, then copied over in a pass across all levels
// a last item adds a minimum scan and the load of the result
// after reset a clearing pass runs before the first item is taken
// a result waits in the output register; the next item is taken meanwhile
// ----------------------------------------------------------------------------
module dpcm_trellis_min_error_top #(
  parameter int MAX_CODES = 16,
  parameter int COST_BITS = 40
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // sample
  input  logic        in_tlast,   // last_sample
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // total_cost
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [62:0] cfg_data
);

  logic [4:0]  entry_count_r;
  logic [62:0] grp0_r, grp1_r;
  logic [17:0] grp2_r;
  logic [143:0] all_codes;
  logic        out_valid_r;
  logic        in_fire;
  dtme_pkg::dp_cmd_t cmd;
  dtme_pkg::dp_sts_t sts;

  assign cfg_ready = 1'b1;
  assign in_fire   = in_tvalid && in_tready;
  assign all_codes = {grp2_r, grp1_r, grp0_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_count_r <= 5'd1;
      grp0_r <= '0;
      grp1_r <= '0;
      grp2_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          dtme_pkg::REG_ENTRY_COUNT: entry_count_r <= cfg_data[4:0];
          dtme_pkg::REG_CODE_GROUP0: grp0_r <= cfg_data;
          dtme_pkg::REG_CODE_GROUP1: grp1_r <= cfg_data;
          dtme_pkg::REG_CODE_GROUP2: grp2_r <= cfg_data[17:0];
          default: ;
        endcase
      end
      if (cmd.out_load) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
    end
  end

  dtme_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_fire  (in_fire),
    .out_busy (out_valid_r && !out_tready),
    .sts      (sts),
    .in_ready (in_tready),
    .cmd      (cmd)
  );

  dtme_datapath #(
    .MAX_CODES (MAX_CODES),
    .COST_BITS (COST_BITS)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .in_sample   (in_tdata),
    .in_last     (in_tlast),
    .entry_count (entry_count_r),
    .codes       (all_codes[MAX_CODES*dtme_pkg::STEP_BITS-1:0]),
    .sts         (sts),
    .best_cost   (out_tdata)
  );

  assign out_tvalid = out_valid_r;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result dropped while stalled");
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> !(out_valid_r && !out_tready))
    else $error("result overwritten");
  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !(cmd.relax || cmd.copy || cmd.min_scan))
    else $error("item taken while busy");

endmodule

// ----- rtl/core/dtme_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtme_ctrl
// sequencer: clearing pass, relax, copy, minimum scan and result hand-off
// ----------------------------------------------------------------------------
module dtme_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_fire,
  input  logic             out_busy,
  input  dtme_pkg::dp_sts_t sts,
  output logic             in_ready,
  output dtme_pkg::dp_cmd_t cmd
);

  dtme_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= dtme_pkg::ST_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      dtme_pkg::ST_INIT: begin
        cmd.init_clear = 1'b1;
        if (sts.sweep_done) state_nxt = dtme_pkg::ST_IDLE;
      end
      dtme_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_fire) begin
          cmd.start = 1'b1;
          state_nxt = dtme_pkg::ST_RELAX;
        end
      end
      dtme_pkg::ST_RELAX: begin
        cmd.relax = 1'b1;
        if (sts.relax_done) state_nxt = dtme_pkg::ST_COPY;
      end
      dtme_pkg::ST_COPY: begin
        cmd.copy = 1'b1;
        if (sts.sweep_done) state_nxt = sts.last_flag ? dtme_pkg::ST_MIN : dtme_pkg::ST_IDLE;
      end
      dtme_pkg::ST_MIN: begin
        cmd.min_scan = 1'b1;
        if (sts.sweep_done) state_nxt = dtme_pkg::ST_OUT;
      end
      dtme_pkg::ST_OUT: begin
        if (!out_busy) begin
          cmd.out_load = 1'b1;
          state_nxt    = dtme_pkg::ST_IDLE;
        end
      end
      default: state_nxt = dtme_pkg::ST_INIT;
    endcase
  end

endmodule

// ----- rtl/core/dtme_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtme_datapath
// cost tables, relax unit (one level and one step a cycle) and minimum scan
// ----------------------------------------------------------------------------
module dtme_datapath #(
  parameter int MAX_CODES = 16,
  parameter int COST_BITS = 40
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  dtme_pkg::dp_cmd_t        cmd,
  input  logic [7:0]               in_sample,
  input  logic                     in_last,
  input  logic [4:0]               entry_count,
  input  logic [MAX_CODES*dtme_pkg::STEP_BITS-1:0] codes,
  output dtme_pkg::dp_sts_t        sts,
  output logic [dtme_pkg::OUT_BITS-1:0] best_cost
);

  localparam int KB = (MAX_CODES > 1) ? $clog2(MAX_CODES) : 1;
  localparam logic [COST_BITS-1:0] COST_ALL = '1;
  localparam int LB = dtme_pkg::LEVEL_BITS;

  logic [COST_BITS-1:0] now_mem [dtme_pkg::LEVELS];
  logic [COST_BITS-1:0] nxt_mem [dtme_pkg::LEVELS];

  logic [LB-1:0] lvl_r, lvl_nxt;
  logic [KB-1:0] k_r, k_nxt;
  logic [LB:0]   sw_r;
  logic [7:0]    x_r;
  logic          last_r;
  logic [4:0]    cnt_r;

  // pipeline: s0 address -> s1 reads -> s2 compare/write -> s3 written value
  logic          v1_r, v2_r, v3_r;
  logic [LB-1:0] t1_r, t2_r, t3_r;
  logic [15:0]   sq1_r;
  logic [COST_BITS-1:0] base1_r, cand2_r, old2_r, w3_r;
  logic [COST_BITS-1:0] nrd_r;
  logic          flush_r;
  logic [1:0]    drain_r;

  logic [COST_BITS-1:0] best_r;
  logic [dtme_pkg::OUT_BITS-1:0] best_out_r;

  // step value and clamped target
  logic signed [dtme_pkg::STEP_BITS-1:0] step;
  logic signed [dtme_pkg::STEP_BITS+1:0] tsum;
  logic [LB-1:0] tgt;
  logic signed [8:0] dd;
  logic [COST_BITS:0] sum2;
  logic [COST_BITS-1:0] cand;
  logic [LB-1:0] t1_fwd;
  logic relax_last;

  assign step = codes[k_r*dtme_pkg::STEP_BITS +: dtme_pkg::STEP_BITS];
  assign tsum = $signed({3'b000, lvl_r}) + {{2{step[dtme_pkg::STEP_BITS-1]}}, step};
  always_comb begin
    if (tsum < 0) tgt = '0;
    else if (tsum > dtme_pkg::TOP_LEVEL) tgt = LB'(dtme_pkg::TOP_LEVEL);
    else tgt = tsum[LB-1:0];
  end
  assign dd = $signed({1'b0, x_r}) - $signed({1'b0, tgt});
  assign relax_last = (lvl_r == LB'(dtme_pkg::TOP_LEVEL)) &&
                      ({1'b0, k_r} == 5'(cnt_r - 5'd1));

  always_comb begin
    lvl_nxt = lvl_r;
    k_nxt   = k_r;
    if ({1'b0, k_r} == 5'(cnt_r - 5'd1)) begin
      k_nxt   = '0;
      lvl_nxt = lvl_r + 1'b1;
    end else begin
      k_nxt = k_r + 1'b1;
    end
  end

  // stage 2 and stage 3 forward of the target write
  assign sum2 = {1'b0, base1_r} + {{(COST_BITS-15){1'b0}}, sq1_r};
  assign cand = (sum2 > {1'b0, COST_ALL}) ? COST_ALL : sum2[COST_BITS-1:0];
  assign t1_fwd = t1_r;

  logic [COST_BITS-1:0] old_fwd;
  always_comb begin
    old_fwd = nrd_r;
    if (v3_r && t3_r == t1_fwd) old_fwd = w3_r;
    if (v2_r && t2_r == t1_fwd) old_fwd = (cand2_r < old2_r) ? cand2_r : old2_r;
  end

  logic [LB-1:0] sw_idx;
  assign sw_idx = sw_r[LB-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sw_r    <= '0;
      v1_r    <= 1'b0;
      v2_r    <= 1'b0;
      v3_r    <= 1'b0;
      flush_r <= 1'b0;
      drain_r <= '0;
      lvl_r   <= '0;
      k_r     <= '0;
    end else begin
      v2_r <= v1_r;
      v3_r <= v2_r;
      if (cmd.start) begin
        x_r     <= in_sample;
        last_r  <= in_last;
        cnt_r   <= (entry_count > 5'(MAX_CODES)) ? 5'(MAX_CODES) : entry_count;
        lvl_r   <= '0;
        k_r     <= '0;
        flush_r <= (entry_count == 5'd0);
        drain_r <= '0;
        sw_r    <= '0;
        v1_r    <= 1'b0;
      end else if (cmd.relax) begin
        v1_r <= 1'b0;
        if (!flush_r) begin
          v1_r   <= (now_mem[lvl_r] != COST_ALL);
          t1_r   <= tgt;
          sq1_r  <= 16'($signed(dd) * $signed(dd));
          base1_r <= now_mem[lvl_r];
          nrd_r  <= nxt_mem[tgt];
          lvl_r  <= lvl_nxt;
          k_r    <= k_nxt;
          if (relax_last) flush_r <= 1'b1;
        end else begin
          drain_r <= drain_r + 1'b1;
        end
      end else if (cmd.init_clear || cmd.copy || cmd.min_scan) begin
        v1_r <= 1'b0;
        sw_r <= sw_r[LB] ? '0 : sw_r + 1'b1;
      end else begin
        v1_r <= 1'b0;
        sw_r <= '0;
      end
    end
    if (v1_r) begin
      cand2_r <= cand;
      old2_r  <= old_fwd;
      t2_r    <= t1_r;
    end
    if (v2_r) begin
      t3_r <= t2_r;
      w3_r <= (cand2_r < old2_r) ? cand2_r : old2_r;
    end
    if (v2_r && cand2_r < old2_r) nxt_mem[t2_r] <= cand2_r;
    if (cmd.init_clear && !sw_r[LB]) begin
      now_mem[sw_idx] <= (sw_idx == LB'(dtme_pkg::START_LEVEL)) ? '0 : COST_ALL;
      nxt_mem[sw_idx] <= COST_ALL;
    end
    if (cmd.copy && !sw_r[LB]) begin
      now_mem[sw_idx] <= nxt_mem[sw_idx];
      nxt_mem[sw_idx] <= COST_ALL;
    end
    if (cmd.min_scan && !sw_r[LB]) begin
      if (sw_r != '0 && now_mem[sw_idx] < best_r) best_r <= now_mem[sw_idx];
      if (sw_r == '0) best_r <= now_mem[sw_idx];
      now_mem[sw_idx] <= (sw_idx == LB'(dtme_pkg::START_LEVEL)) ? '0 : COST_ALL;
    end
    if (cmd.out_load) begin
      best_out_r <= (best_r > COST_BITS'(64'hFF_FFFF_FFFF)) ? '1 :
                    dtme_pkg::OUT_BITS'(best_r);
    end
  end

  assign sts.relax_done = flush_r && (drain_r == 2'd3);
  assign sts.sweep_done = sw_r[LB];
  assign sts.last_flag  = last_r;
  assign best_cost      = best_out_r;

endmodule
